### rtl/line_substring_match_finder_macros.svh
// ----------------------------------------------------------------------------
// line_substring_match_finder_macros.svh
// Assertion macros used by the checker of the substring match finder.
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_MATCH_FINDER_MACROS_SVH
`define LINE_SUBSTRING_MATCH_FINDER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LSMF_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lsmf assertion failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LSMF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lsmf assertion failed");

`endif

### rtl/lsmf_pkg.sv
// ----------------------------------------------------------------------------
// lsmf_pkg
// Types, constants and helpers shared by the substring match finder.
// ----------------------------------------------------------------------------
package lsmf_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned PAT_W  = 64;
	localparam int unsigned LEN_W  = 5;
	localparam int unsigned SUP_W  = 4;
	localparam int unsigned CNT_W  = 32;
	localparam int unsigned IDX_W  = 2;

	localparam logic [BYTE_W-1:0] NEWLINE_BYTE = 8'd10;
	localparam logic [CNT_W-1:0]  CNT_SAT      = '1;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_PAT_LOW  = 2'd0,
		REG_PAT_HIGH = 2'd1,
		REG_PAT_LEN  = 2'd2
	} reg_idx_t;

	// Controls broadcast along the window chain
	typedef struct packed {
		logic shift;    // a text byte is accepted this cycle
		logic restart;  // start flag: older window contents are void
		logic flush;    // newline: window empties after this byte
	} shift_ctrl_t;

	typedef struct packed {
		logic [CNT_W-1:0] line_number;
		logic [CNT_W-1:0] match_column;
		logic             first_in_line;
	} result_t;

	// Pick pattern byte idx out of the two 64-bit pattern registers
	function automatic logic [BYTE_W-1:0] pat_byte(
		input logic [PAT_W-1:0] lo,
		input logic [PAT_W-1:0] hi,
		input logic [3:0]       idx
	);
		logic [PAT_W-1:0] w;
		w = idx[3] ? hi : lo;
		return w[{idx[2:0], 3'b000} +: BYTE_W];
	endfunction

endpackage

### rtl/lsmf_cell.sv
// ----------------------------------------------------------------------------
// lsmf_cell
// One window position: holds a byte and its valid flag, compares against
// the pattern byte aligned to it and hands its byte to the next cell.
// ----------------------------------------------------------------------------
module lsmf_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lsmf_pkg::shift_ctrl_t         ctrl,
	input  logic [lsmf_pkg::BYTE_W-1:0]   byte_in,
	input  logic                          valid_in,
	input  logic [lsmf_pkg::BYTE_W-1:0]   exp_byte,
	input  logic                          in_use,
	output logic [lsmf_pkg::BYTE_W-1:0]   byte_out,
	output logic                          valid_out,
	output logic                          ok
);

	logic [lsmf_pkg::BYTE_W-1:0] byte_q;
	logic                        valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.shift) begin
			valid_q <= valid_in && !ctrl.flush;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			byte_q <= byte_in;
		end
	end

	// A start flag voids the stored byte before it is compared
	assign valid_out = valid_q && !ctrl.restart;
	assign byte_out  = byte_q;
	assign ok        = !in_use || (valid_out && (byte_q == exp_byte));

endmodule

### rtl/lsmf_out_buf.sv
// ----------------------------------------------------------------------------
// lsmf_out_buf
// Output register with a skid stage behind it for result transactions.
// ----------------------------------------------------------------------------
module lsmf_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  lsmf_pkg::result_t push_data,
	output logic              space,
	output logic              out_valid,
	input  logic              out_ready,
	output lsmf_pkg::result_t out_data
);

	logic              out_valid_q;
	logic              skid_valid_q;
	lsmf_pkg::result_t out_data_q;
	lsmf_pkg::result_t skid_data_q;
	logic              pop;

	assign pop   = out_valid_q && out_ready;
	assign space = !skid_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_data_q <= skid_data_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_data_q <= push_data;
			end else begin
				out_data_q <= push_data;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### rtl/line_substring_match_finder.sv
// A match goes into the output register, or into the skid stage while the output register holds a stalled result.
// Throughput: one text byte per cycle unless the input stalls; the window cells compare in parallel.
// Input stalls only while both the output register and the skid stage hold results.
// Reset (arst_n low): empty window, line 1, column 0, pattern length 1, pattern zero.
// ----------------------------------------------------------------------------
// line_substring_match_finder
// Streaming search for a 1..MAX_PATTERN byte pattern within text lines,
// reporting leftmost non-overlapping matches with line and column.
// ----------------------------------------------------------------------------
module line_substring_match_finder #(
	parameter int unsigned MAX_PATTERN = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lsmf_pkg::IDX_W-1:0]    cfg_index,
	input  logic [lsmf_pkg::PAT_W-1:0]    cfg_data,
	// text input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [lsmf_pkg::BYTE_W-1:0]   text_byte,
	input  logic                          start_of_text,
	// match result channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [lsmf_pkg::CNT_W-1:0]    line_number,
	output logic [lsmf_pkg::CNT_W-1:0]    match_column,
	output logic                          first_in_line
);

	// The window keeps the last MAX_PATTERN-1 bytes; always at least one cell
	localparam int unsigned NCELL = (MAX_PATTERN > 1) ? MAX_PATTERN - 1 : 1;

	// ------------------------------------------------------------------
	// Configuration registers; writes always complete, cfg_ready is high in every cycle
	// ------------------------------------------------------------------
	logic [lsmf_pkg::PAT_W-1:0] pat_low_q;
	logic [lsmf_pkg::PAT_W-1:0] pat_high_q;
	logic [lsmf_pkg::LEN_W-1:0] pat_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_low_q  <= '0;
			pat_high_q <= '0;
			pat_len_q  <= lsmf_pkg::LEN_W'(1);
		end else if (cfg_valid) begin
			unique case (lsmf_pkg::reg_idx_t'(cfg_index))
				lsmf_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_data;
				lsmf_pkg::REG_PAT_HIGH: pat_high_q <= cfg_data;
				lsmf_pkg::REG_PAT_LEN:  pat_len_q  <= cfg_data[lsmf_pkg::LEN_W-1:0];
				default: ; // unmapped index: drop the write
			endcase
		end
	end

	// Clamp the length to 1..MAX_PATTERN
	logic [lsmf_pkg::LEN_W-1:0] len;
	always_comb begin
		if (pat_len_q == '0) begin
			len = lsmf_pkg::LEN_W'(1);
		end else if (pat_len_q > lsmf_pkg::LEN_W'(MAX_PATTERN)) begin
			len = lsmf_pkg::LEN_W'(MAX_PATTERN);
		end else begin
			len = pat_len_q;
		end
	end

	// ------------------------------------------------------------------
	// Input acceptance and chain control
	// ------------------------------------------------------------------
	logic                   buf_space;
	logic                   accept;
	logic                   is_newline;
	lsmf_pkg::shift_ctrl_t  ctrl;

	assign in_ready   = buf_space;
	assign accept     = in_valid && in_ready;
	assign is_newline = (text_byte == lsmf_pkg::NEWLINE_BYTE);

	always_comb begin
		ctrl.shift   = accept;
		ctrl.restart = start_of_text;
		ctrl.flush   = is_newline;
	end

	// ------------------------------------------------------------------
	// Window chain: cell 0 holds the most recent byte of the line.
	// Cell k lines up with pattern byte len-2-k and is in use when
	// k < len-1. A cell that is empty and in use blocks the match,
	// which covers the window-fill check.
	// ------------------------------------------------------------------
	logic [lsmf_pkg::BYTE_W-1:0] cell_byte [NCELL];
	logic [NCELL-1:0]            cell_valid;
	logic [NCELL-1:0]            cell_ok;

	for (genvar k = 0; k < NCELL; k++) begin : g_cell
		logic [lsmf_pkg::BYTE_W-1:0] byte_in;
		logic                        valid_in;
		logic                        in_use;
		logic [lsmf_pkg::LEN_W-1:0]  exp_idx;
		logic [lsmf_pkg::BYTE_W-1:0] exp_byte;

		if (k == 0) begin : g_head
			assign byte_in  = text_byte;
			assign valid_in = 1'b1;
		end else begin : g_body
			assign byte_in  = cell_byte[k-1];
			assign valid_in = cell_valid[k-1];
		end

		assign in_use   = (lsmf_pkg::LEN_W'(k) + lsmf_pkg::LEN_W'(1)) < len;
		assign exp_idx  = len - lsmf_pkg::LEN_W'(2) - lsmf_pkg::LEN_W'(k);
		assign exp_byte = lsmf_pkg::pat_byte(pat_low_q, pat_high_q, exp_idx[3:0]);

		lsmf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.byte_in   (byte_in),
			.valid_in  (valid_in),
			.exp_byte  (exp_byte),
			.in_use    (in_use),
			.byte_out  (cell_byte[k]),
			.valid_out (cell_valid[k]),
			.ok        (cell_ok[k])
		);
	end

	// Last pattern byte meets the incoming byte
	logic [lsmf_pkg::LEN_W-1:0] last_idx;
	logic                       hit;

	assign last_idx = len - lsmf_pkg::LEN_W'(1);
	assign hit = (lsmf_pkg::pat_byte(pat_low_q, pat_high_q, last_idx[3:0]) == text_byte)
		&& (&cell_ok);

	// ------------------------------------------------------------------
	// Line state: column, line, overlap suppression, first-match flag.
	// A start flag resets these before the byte is handled.
	// ------------------------------------------------------------------
	logic [lsmf_pkg::CNT_W-1:0] col_q;
	logic [lsmf_pkg::CNT_W-1:0] line_q;
	logic [lsmf_pkg::SUP_W-1:0] sup_q;
	logic                       has_match_q;

	logic [lsmf_pkg::CNT_W-1:0] col_e;
	logic [lsmf_pkg::CNT_W-1:0] line_e;
	logic [lsmf_pkg::SUP_W-1:0] sup_e;
	logic                       has_match_e;
	logic                       report;
	lsmf_pkg::result_t          res;

	assign col_e       = start_of_text ? '0 : col_q;
	assign line_e      = start_of_text ? lsmf_pkg::CNT_W'(1) : line_q;
	assign sup_e       = start_of_text ? '0 : sup_q;
	assign has_match_e = start_of_text ? 1'b0 : has_match_q;

	// A newline never reports; an overlapping end is dropped
	assign report = accept && !is_newline && hit && (sup_e == '0);

	always_comb begin
		res.line_number   = line_e;
		res.match_column  = (col_e == lsmf_pkg::CNT_SAT) ? lsmf_pkg::CNT_SAT
			: col_e - lsmf_pkg::CNT_W'(last_idx);
		res.first_in_line = !has_match_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			line_q      <= lsmf_pkg::CNT_W'(1);
			sup_q       <= '0;
			has_match_q <= 1'b0;
		end else if (accept) begin
			if (is_newline) begin
				col_q       <= '0;
				sup_q       <= '0;
				has_match_q <= 1'b0;
				line_q      <= (line_e == lsmf_pkg::CNT_SAT) ? line_e
					: line_e + lsmf_pkg::CNT_W'(1);
			end else begin
				line_q <= line_e;
				col_q  <= (col_e == lsmf_pkg::CNT_SAT) ? col_e
					: col_e + lsmf_pkg::CNT_W'(1);
				if (report) begin
					// hold off match ends that would overlap this one
					has_match_q <= 1'b1;
					sup_q       <= last_idx[lsmf_pkg::SUP_W-1:0];
				end else begin
					has_match_q <= has_match_e;
					sup_q       <= (sup_e != '0) ? sup_e - lsmf_pkg::SUP_W'(1) : sup_e;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result transaction buffer
	// ------------------------------------------------------------------
	lsmf_pkg::result_t out_data;

	lsmf_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (report),
		.push_data (res),
		.space     (buf_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign line_number   = out_data.line_number;
	assign match_column  = out_data.match_column;
	assign first_in_line = out_data.first_in_line;

endmodule

### rtl/lsmf_checker.sv
// ----------------------------------------------------------------------------
// lsmf_checker
// Port-level checks of the substring match finder, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_substring_match_finder_macros.svh"

module lsmf_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic [lsmf_pkg::BYTE_W-1:0] text_byte,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [lsmf_pkg::CNT_W-1:0]  line_number,
	input logic [lsmf_pkg::CNT_W-1:0]  match_column
);

	// A stalled result holds its payload
	`LSMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(line_number) && $stable(match_column))

	// Line numbers are 1-based
	`LSMF_ASSERT_NOW(a_line_nonzero, out_valid, line_number != '0)

	// With no result pending the skid stage is empty, so input is taken
	`LSMF_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready)

	// A newline transaction produces no result
	`LSMF_ASSERT_NEXT(a_newline_silent, in_valid && in_ready && !out_valid && text_byte == lsmf_pkg::NEWLINE_BYTE, !out_valid)

endmodule

bind line_substring_match_finder lsmf_checker u_lsmf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.text_byte    (text_byte),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.line_number  (line_number),
	.match_column (match_column)
);

### test/lsmf_match_checker.sv
// ----------------------------------------------------------------------------
// lsmf_match_checker
// Watches the register, text and match channels of the substring match
// finder, tracks the line state on its own and compares every match.
// ----------------------------------------------------------------------------
module lsmf_match_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	input  logic                        cfg_ready,
	input  logic [lsmf_pkg::IDX_W-1:0]  cfg_index,
	input  logic [lsmf_pkg::PAT_W-1:0]  cfg_data,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [lsmf_pkg::BYTE_W-1:0] text_byte,
	input  logic                        start_of_text,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [lsmf_pkg::CNT_W-1:0]  line_number,
	input  logic [lsmf_pkg::CNT_W-1:0]  match_column,
	input  logic                        first_in_line,
	output int unsigned                 pending,
	output int unsigned                 matches_seen,
	output int unsigned                 fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import lsmf_pkg::*;

	localparam int unsigned HIST_DEPTH = 15;
	localparam int unsigned LONGEST    = 16;

	logic [PAT_W-1:0]  pat_lo;
	logic [PAT_W-1:0]  pat_hi;
	logic [LEN_W-1:0]  pat_len;
	logic [BYTE_W-1:0] history [HIST_DEPTH];
	int unsigned       hist_fill;
	logic [CNT_W-1:0]  col_next;
	logic [CNT_W-1:0]  cur_line;
	int unsigned       skip_ends;
	logic              seen_in_line;
	result_t           match_fifo [$];

	function automatic logic [BYTE_W-1:0] pattern_at(input int unsigned idx);
		logic [2*PAT_W-1:0] both;
		both = {pat_hi, pat_lo};
		return both[idx*BYTE_W +: BYTE_W];
	endfunction

	task automatic clear_line_state();
		for (int i = 0; i < HIST_DEPTH; i++)
			history[i] = '0;
		hist_fill    = 0;
		col_next     = '0;
		skip_ends    = 0;
		seen_in_line = 1'b0;
	endtask

	// Advance the line state by one text byte; queue the match it ends, if any.
	task automatic scan_byte(input logic [BYTE_W-1:0] b, input logic sot);
		int unsigned span;
		logic        hit;
		result_t     m;
		if (sot) begin
			clear_line_state();
			cur_line = 1;
		end
		if (b == NEWLINE_BYTE) begin
			clear_line_state();
			if (cur_line != CNT_SAT)
				cur_line = cur_line + 1;
		end else begin
			span = 32'(pat_len);
			if (span == 0)
				span = 1;
			if (span > LONGEST)
				span = LONGEST;
			hit = (hist_fill >= span - 1) && (pattern_at(span - 1) == b);
			for (int unsigned i = 1; i < span; i++)
				if (pattern_at(span - 1 - i) != history[i - 1])
					hit = 1'b0;
			if (hit && skip_ends == 0) begin
				m.line_number   = cur_line;
				m.match_column  = (col_next == CNT_SAT) ? CNT_SAT : col_next - (span - 1);
				m.first_in_line = !seen_in_line;
				match_fifo.insert(match_fifo.size(), m);
				seen_in_line = 1'b1;
				skip_ends    = span - 1;
			end else if (skip_ends > 0) begin
				skip_ends--;
			end
			for (int i = HIST_DEPTH - 1; i > 0; i--)
				history[i] = history[i - 1];
			history[0] = b;
			if (hist_fill < HIST_DEPTH)
				hist_fill++;
			if (col_next != CNT_SAT)
				col_next = col_next + 1;
		end
	endtask

	task automatic compare_match();
		result_t exp_m;
		logic    bad;
		matches_seen++;
		if (match_fifo.size() == 0) begin
			$error("unexpected match: line_number %0d match_column %0d first_in_line %0b",
				line_number, match_column, first_in_line);
			fail_count++;
		end else begin
			exp_m = match_fifo.pop_front();
			bad   = 1'b0;
			if (line_number !== exp_m.line_number) begin
				bad = 1'b1;
				$error("line_number: expected %0d, got %0d", exp_m.line_number, line_number);
			end
			if (match_column !== exp_m.match_column) begin
				bad = 1'b1;
				$error("match_column: expected %0d, got %0d", exp_m.match_column,
					match_column);
			end
			if (first_in_line !== exp_m.first_in_line) begin
				bad = 1'b1;
				$error("first_in_line: expected %0b, got %0b", exp_m.first_in_line,
					first_in_line);
			end
			if (bad)
				fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_lo  = '0;
			pat_hi  = '0;
			pat_len = LEN_W'(1);
			clear_line_state();
			cur_line = 1;
			match_fifo.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PAT_LOW:  pat_lo  = cfg_data;
					REG_PAT_HIGH: pat_hi  = cfg_data;
					REG_PAT_LEN:  pat_len = cfg_data[LEN_W-1:0];
					default:      ;
				endcase
			end
			// queue first: a match is registered in the output buffer, so it never leaves with its byte
			if (in_valid && in_ready)
				scan_byte(text_byte, start_of_text);
			if (out_valid && out_ready)
				compare_match();
			pending = match_fifo.size();
		end
	end

endmodule

### test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives text and search settings into the substring match finder: a short
// directed run, then random phases of pattern copies, broken copies, newlines
// and start flags, with random gaps on both channels. The checker beside the
// block predicts every match and counts failures.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lsmf_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 500000;
	localparam int unsigned RANDOM_ITEMS  = 900;
	// a byte that ends no match may still be in flight when nothing is pending
	localparam int unsigned SETTLE_CYCLES = 4;
	// index that decodes to no register
	localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [IDX_W-1:0]  cfg_index;
	logic [PAT_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_ready;
	logic [BYTE_W-1:0] text_byte;
	logic              start_of_text;
	logic              out_valid;
	logic              out_ready;
	logic [CNT_W-1:0]  line_number;
	logic [CNT_W-1:0]  match_column;
	logic              first_in_line;

	int unsigned pending;
	int unsigned matches_seen;
	int unsigned fail_count;

	int unsigned cycle_count = 0;
	int unsigned bytes_sent  = 0;
	int unsigned cfg_writes  = 0;
	int unsigned settings    = 0;
	bit          no_gaps     = 1'b0;

	// what the block was last told, used only to build pattern copies
	logic [PAT_W-1:0]  shadow_lo  = '0;
	logic [PAT_W-1:0]  shadow_hi  = '0;
	logic [LEN_W-1:0]  shadow_len = 5'd1;
	logic [BYTE_W-1:0] letters [3];

	line_substring_match_finder dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_byte     (text_byte),
		.start_of_text (start_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.line_number   (line_number),
		.match_column  (match_column),
		.first_in_line (first_in_line)
	);

	lsmf_match_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.text_byte     (text_byte),
		.start_of_text (start_of_text),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.line_number   (line_number),
		.match_column  (match_column),
		.first_in_line (first_in_line),
		.pending       (pending),
		.matches_seen  (matches_seen),
		.fail_count    (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// Watchdog: a hung handshake ends the run here.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// Result side: alternate ready runs and stalls, mostly short, a few long,
	// now and then a long stretch of steady ready.
	initial begin : result_sink
		int unsigned hold;
		int unsigned stall;
		int unsigned r;
		out_ready <= 1'b0;
		forever begin
			hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
			r = $urandom_range(0, 99);
			if (r < 60)
				stall = $urandom_range(1, 2);
			else if (r < 92)
				stall = $urandom_range(3, 8);
			else
				stall = $urandom_range(20, 40);
			@(posedge clk);
			out_ready <= 1'b1;
			repeat (hold) @(posedge clk);
			out_ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	// Offer one text byte and hold it until the transaction completes. Valid
	// stays high on return so that a back-to-back byte follows without a gap.
	task automatic send_text(input logic [BYTE_W-1:0] b, input logic sot);
		int unsigned gap;
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			gap = 0;
		else if (r < 85)
			gap = $urandom_range(1, 3);
		else if (r < 97)
			gap = $urandom_range(4, 10);
		else
			gap = $urandom_range(20, 40);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		text_byte     <= b;
		start_of_text <= sot;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
	endtask

	// Hold off the sender until every predicted match has come out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register transaction; cfg_valid is left high for a following write.
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [PAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_writes++;
	endtask

	// Write the registers selected by mask (bit i for index i), then drop valid.
	task automatic program_search(input logic [PAT_W-1:0] lo, input logic [PAT_W-1:0] hi,
			input logic [PAT_W-1:0] len_word, input logic [3:0] mask);
		if (mask[REG_PAT_LOW]) begin
			write_reg(REG_PAT_LOW, lo);
			shadow_lo = lo;
		end
		if (mask[REG_PAT_HIGH]) begin
			write_reg(REG_PAT_HIGH, hi);
			shadow_hi = hi;
		end
		if (mask[REG_PAT_LEN]) begin
			write_reg(REG_PAT_LEN, len_word);
			shadow_len = len_word[LEN_W-1:0];
		end
		if (mask[REG_SPARE])
			write_reg(REG_SPARE, {$urandom, $urandom});
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Send the active pattern once; a broken copy has one byte replaced,
	// sometimes by a newline that splits it across two lines.
	task automatic send_copy(input bit broken);
		int unsigned       span;
		int unsigned       flaw;
		logic [2*PAT_W-1:0] both;
		logic [BYTE_W-1:0] b;
		span = 32'(shadow_len);
		if (span == 0)
			span = 1;
		if (span > 16)
			span = 16;
		both = {shadow_hi, shadow_lo};
		flaw = broken ? $urandom_range(0, span - 1) : span;
		for (int unsigned i = 0; i < span; i++) begin
			b = both[i*BYTE_W +: BYTE_W];
			if (i == flaw)
				b = ($urandom_range(0, 3) == 0) ? NEWLINE_BYTE : letters[$urandom_range(0, 2)];
			send_text(b, 1'b0);
		end
	endtask

	initial begin : stimulus
		int unsigned       r;
		int unsigned       run;
		int unsigned       random_start;
		logic [PAT_W-1:0]  lo;
		logic [PAT_W-1:0]  hi;
		logic [PAT_W-1:0]  len_word;
		logic [LEN_W-1:0]  len5;
		logic [3:0]        mask;
		logic [BYTE_W-1:0] b;
		bit                first_phase;

		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= REG_PAT_LOW;
		cfg_data      <= '0;
		in_valid      <= 1'b0;
		text_byte     <= '0;
		start_of_text <= 1'b0;
		letters[0] = 8'h61;
		letters[1] = 8'h62;
		letters[2] = 8'h63;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset search: one zero byte. Repeats in a line, a newline, then a
		// start flag that pulls the line count back to one.
		send_text(8'h00, 1'b0);
		send_text(8'h00, 1'b0);
		send_text(NEWLINE_BYTE, 1'b0);
		send_text(8'h00, 1'b0);
		send_text(8'h00, 1'b1);
		drain();

		// "aa" over "aaaa": overlapping ends must be skipped.
		program_search(64'hFFFF_FFFF_FFFF_6161, '1, 64'd2, 4'b0111);
		repeat (4) send_text(8'h61, 1'b0);
		drain();

		// Length field zero acts as one; also poke the unused index.
		program_search('0, '0, 64'hFFFF_FFFF_FFFF_FFE0, 4'b1100);
		send_text(8'h61, 1'b0);
		drain();

		// Length above the maximum acts as sixteen; full-range pattern bytes.
		program_search(64'h80FF_7F00_55AA_01FE, 64'h0123_4567_89AB_CDEF, 64'd31, 4'b0111);
		send_copy(1'b0);

		// Random phases. Each starts from idle, rewrites some registers and
		// streams text that is mostly pattern copies over a small alphabet.
		random_start = bytes_sent;
		first_phase  = 1'b1;
		while ((bytes_sent - random_start) < RANDOM_ITEMS) begin
			drain();
			for (int i = 0; i < 3; i++)
				letters[i] = ($urandom_range(0, 1) == 0) ? 8'(8'h61 + $urandom_range(0, 3))
					: 8'($urandom_range(0, 255));
			for (int i = 0; i < 16; i++) begin
				b = letters[$urandom_range(0, 2)];
				if (i < 8)
					lo[i*8 +: 8] = b;
				else
					hi[(i-8)*8 +: 8] = b;
			end
			r = $urandom_range(0, 99);
			if (r < 35)
				len5 = 5'($urandom_range(1, 4));
			else if (r < 55)
				len5 = 5'd16;
			else if (r < 75)
				len5 = 5'($urandom_range(5, 15));
			else if (r < 85)
				len5 = 5'd0;
			else
				len5 = 5'($urandom_range(17, 31));
			len_word = {$urandom, $urandom};
			len_word[LEN_W-1:0] = len5;
			// the first phase writes everything; later ones may change only some
			mask = first_phase ? 4'b0111 : 4'($urandom_range(1, 15));
			first_phase = 1'b0;
			program_search(lo, hi, len_word, mask);
			no_gaps = ($urandom_range(0, 3) == 0);
			run = $urandom_range(30, 80);
			for (int unsigned k = 0; k < run; k++) begin
				r = $urandom_range(0, 99);
				if (r < 25)
					send_copy(1'b0);
				else if (r < 32)
					send_copy(1'b1);
				else if (r < 72)
					send_text(letters[$urandom_range(0, 2)], 1'b0);
				else if (r < 84)
					send_text(8'($urandom_range(0, 255)), 1'b0);
				else if (r < 91)
					send_text(NEWLINE_BYTE, 1'b0);
				else if (r < 94)
					send_text(letters[$urandom_range(0, 2)], 1'b1);
				else if (r < 96)
					drain();
				else
					send_text(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
		end

		// Let the last matches out, then give the block a little more time.
		drain();
		repeat (10) @(posedge clk);

		$display("tb: %0d text bytes sent, %0d matches compared", bytes_sent, matches_seen);
		$display("tb: %0d register writes across %0d search settings", cfg_writes, settings);
		if (fail_count == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
